### src/thermistor_table_interpolator_macros.svh
`ifndef THERMISTOR_TABLE_INTERPOLATOR_MACROS_SVH
`define THERMISTOR_TABLE_INTERPOLATOR_MACROS_SVH

// same-cycle implication
`define TTI_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TTI_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/tti_pkg.sv
package tti_pkg;

	localparam int TABLE_DEPTH   = 256;
	localparam int SAMPLE_BITS   = 12;
	localparam int FRACTION_BITS = 8;

	// fixed field widths
	localparam int OP_W          = 1;
	localparam int ENTRY_INDEX_W = 8;
	localparam int ENTRY_VALUE_W = 12;
	localparam int SAMPLE_W      = 12;
	localparam int STATUS_W      = 3;
	localparam int TEMP_W        = 16;
	localparam int THRESH_W      = 12;
	localparam int COUNT_W       = 9;
	localparam int BASE_W        = 8;
	localparam int REG_INDEX_W   = 2;
	localparam int CFG_DATA_W    = 12;

	// derived widths
	localparam int IDX_W     = $clog2(TABLE_DEPTH);
	localparam int PTR_W     = IDX_W + 1;
	localparam int NUM_W     = SAMPLE_BITS + FRACTION_BITS;
	localparam int DIFF_W    = SAMPLE_BITS + 1;
	localparam int BM_W      = ((BASE_W > IDX_W + 1) ? BASE_W : IDX_W + 1) + 1;
	localparam int ACC_W     = (((BM_W + FRACTION_BITS) > (NUM_W + 1)) ?
	                            (BM_W + FRACTION_BITS) : (NUM_W + 1)) + 1;
	localparam int DIV_CNT_W = $clog2(NUM_W + 1);

	localparam int TEMP_MAX = 32767;
	localparam int TEMP_MIN = -32768;

	localparam logic [THRESH_W-1:0]      SHORT_RESET = 12'd20;
	localparam logic [THRESH_W-1:0]      OPEN_RESET  = 12'd4090;
	localparam logic [COUNT_W-1:0]       COUNT_RESET = 9'd161;
	localparam logic signed [BASE_W-1:0] BASE_RESET  = -8'sd40;

	typedef enum logic [OP_W-1:0] {
		OP_LOAD    = 1'b0,
		OP_CONVERT = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 3'd0,
		ST_SHORT = 3'd1,
		ST_OPEN  = 3'd2,
		ST_ABOVE = 3'd3,
		ST_BELOW = 3'd4
	} status_t;

	typedef enum logic [REG_INDEX_W-1:0] {
		REG_SHORT = 2'd0,
		REG_OPEN  = 2'd1,
		REG_COUNT = 2'd2,
		REG_BASE  = 2'd3
	} reg_index_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_ENDS_RD,
		S_ENDS_CHK,
		S_SRCH_RD,
		S_SRCH_CHK,
		S_DIV,
		S_FINISH,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                   start;
		logic [NUM_W-1:0]       dividend;
		logic [SAMPLE_BITS-1:0] divisor;
	} div_ctl_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quotient;
	} div_sts_t;

endpackage

### src/tti_item_if.sv
interface tti_item_if;
	logic                                valid;
	logic                                ready;
	logic [tti_pkg::OP_W-1:0]            op;
	logic [tti_pkg::ENTRY_INDEX_W-1:0]   entry_index;
	logic [tti_pkg::ENTRY_VALUE_W-1:0]   entry_value;
	logic [tti_pkg::SAMPLE_W-1:0]        sample;

	modport source (output valid, op, entry_index, entry_value, sample, input ready);
	modport sink (input valid, op, entry_index, entry_value, sample, output ready);
endinterface

### src/tti_result_if.sv
interface tti_result_if;
	logic                                valid;
	logic                                ready;
	logic [tti_pkg::STATUS_W-1:0]        status;
	logic signed [tti_pkg::TEMP_W-1:0]   temperature_q8;

	modport source (output valid, status, temperature_q8, input ready);
	modport sink (input valid, status, temperature_q8, output ready);
endinterface

### src/tti_cfg_if.sv
interface tti_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [tti_pkg::REG_INDEX_W-1:0]   reg_index;
	logic [tti_pkg::CFG_DATA_W-1:0]    wdata;

	modport source (output valid, reg_index, wdata, input ready);
	modport sink (input valid, reg_index, wdata, output ready);
endinterface

### src/tti_ram.sv
module tti_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

### src/tti_div.sv
// restoring divider, one quotient bit per cycle
module tti_div (
	input  logic              clk,
	input  logic              arst_n,
	input  tti_pkg::div_ctl_t ctl,
	output tti_pkg::div_sts_t sts
);

	logic [tti_pkg::SAMPLE_BITS-1:0] rem_q;
	logic [tti_pkg::SAMPLE_BITS-1:0] dvs_q;
	logic [tti_pkg::NUM_W-1:0]       quot_q;
	logic [tti_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic                            busy_q;
	logic                            done_q;

	logic [tti_pkg::SAMPLE_BITS:0]   trial;
	logic                            fits;
	logic [tti_pkg::SAMPLE_BITS-1:0] rem_nxt;

	always_comb begin
		trial   = {rem_q, quot_q[tti_pkg::NUM_W-1]};
		fits    = (trial >= {1'b0, dvs_q});
		rem_nxt = fits ? tti_pkg::SAMPLE_BITS'(trial - {1'b0, dvs_q})
		               : trial[tti_pkg::SAMPLE_BITS-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= tti_pkg::DIV_CNT_W'(tti_pkg::NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == tti_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			rem_q  <= '0;
			dvs_q  <= ctl.divisor;
			quot_q <= ctl.dividend;
		end else if (busy_q) begin
			rem_q  <= rem_nxt;
			quot_q <= {quot_q[tti_pkg::NUM_W-2:0], fits};
		end
	end

	assign sts.busy     = busy_q;
	assign sts.done     = done_q;
	assign sts.quotient = quot_q;

endmodule

### src/thermistor_table_interpolator.sv
// Load beat: written to the table in the accept cycle; ready again next cycle.
// Convert beat: short/open go straight to the result register, above/below after the
// end-entry reads; otherwise a binary search over the table, then the serial divide
// unless the segment is flat or ends on the last entry.
// One convert in flight; the serial divider and the search reads set the rate.
// arst_n clears the sequencer and the result valid flag, and sets the config regs to their reset values.
module thermistor_table_interpolator (
	input  logic          clk,
	input  logic          arst_n,
	tti_item_if.sink      item,
	tti_result_if.source  result,
	tti_cfg_if.sink       cfg
);

	// ------------------------------------------------------------------
	// Configuration registers, always ready. Write only while idle; block does not check.
	// ------------------------------------------------------------------
	logic [tti_pkg::THRESH_W-1:0]      short_q;
	logic [tti_pkg::THRESH_W-1:0]      open_q;
	logic [tti_pkg::COUNT_W-1:0]       count_q;
	logic signed [tti_pkg::BASE_W-1:0] base_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q <= tti_pkg::SHORT_RESET;
			open_q  <= tti_pkg::OPEN_RESET;
			count_q <= tti_pkg::COUNT_RESET;
			base_q  <= tti_pkg::BASE_RESET;
		end else if (cfg.valid) begin
			unique case (tti_pkg::reg_index_t'(cfg.reg_index))
				tti_pkg::REG_SHORT: short_q <= cfg.wdata[tti_pkg::THRESH_W-1:0];
				tti_pkg::REG_OPEN:  open_q  <= cfg.wdata[tti_pkg::THRESH_W-1:0];
				tti_pkg::REG_COUNT: count_q <= cfg.wdata[tti_pkg::COUNT_W-1:0];
				tti_pkg::REG_BASE:  base_q  <= cfg.wdata[tti_pkg::BASE_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Sequencer and working registers
	// ------------------------------------------------------------------
	tti_pkg::state_t                   state_q, state_nxt;
	logic [tti_pkg::SAMPLE_BITS-1:0]   s_q;      // sample under conversion
	logic [tti_pkg::IDX_W-1:0]         last_q;   // index of last table entry in use
	logic [tti_pkg::PTR_W-1:0]         lo_q;     // search window, lo may pass last
	logic [tti_pkg::PTR_W-1:0]         hi_q;
	logic [tti_pkg::IDX_W-1:0]         mid_q;
	tti_pkg::status_t                  status_q;
	logic                              neg_q;    // quotient sign
	logic                              frac_en_q;
	logic signed [tti_pkg::TEMP_W-1:0] res_q;

	// result register, frees the sequencer while a beat waits downstream
	logic                              out_valid_q;
	logic [tti_pkg::STATUS_W-1:0]      out_status_q;
	logic signed [tti_pkg::TEMP_W-1:0] out_temp_q;

	// table memory
	logic                              ram_we;
	logic [tti_pkg::IDX_W-1:0]         ram_waddr;
	logic [tti_pkg::IDX_W-1:0]         raddr_a, raddr_b;
	logic [tti_pkg::SAMPLE_BITS-1:0]   rd_a, rd_b;

	tti_pkg::div_ctl_t                 div_ctl;
	tti_pkg::div_sts_t                 div_sts;

	// accept-side decode
	logic                              acc_item;
	logic                              acc_conv;
	logic [tti_pkg::SAMPLE_BITS-1:0]   smp_c;
	logic [tti_pkg::IDX_W-1:0]         last_c;
	logic                              short_c, open_c;
	logic                              above_c, below_c;

	// search step
	logic                              found_c;
	logic [tti_pkg::PTR_W-1:0]         lo_nxt, hi_nxt;
	logic [tti_pkg::IDX_W-1:0]         mid_nxt;
	logic [tti_pkg::PTR_W-1:0]         mid_p1, mid_m1;
	logic [tti_pkg::PTR_W:0]           sum_c;

	// interpolation
	logic signed [tti_pkg::DIFF_W-1:0] num_c, den_c;
	logic [tti_pkg::SAMPLE_BITS-1:0]   abs_num, abs_den;
	logic                              frac_need_c;
	logic signed [tti_pkg::BM_W-1:0]   bm_c;
	logic signed [tti_pkg::NUM_W:0]    q_c;
	logic signed [tti_pkg::ACC_W-1:0]  frac_c, acc_c;
	logic signed [tti_pkg::TEMP_W-1:0] sat_c;
	logic                              out_free;

	assign out_free = !out_valid_q || result.ready;
	assign acc_item = item.valid && item.ready;
	assign acc_conv = acc_item && (tti_pkg::op_t'(item.op) == tti_pkg::OP_CONVERT);

	tti_ram #(
		.WIDTH(tti_pkg::SAMPLE_BITS),
		.DEPTH(tti_pkg::TABLE_DEPTH)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.waddr   (ram_waddr),
		.wdata   (tti_pkg::SAMPLE_BITS'(item.entry_value)),
		.raddr_a (raddr_a),
		.raddr_b (raddr_b),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	tti_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.sts    (div_sts)
	);

	// ------------------------------------------------------------------
	// Datapath decode
	// ------------------------------------------------------------------
	always_comb begin
		// entry count clamped to 2..TABLE_DEPTH
		smp_c = tti_pkg::SAMPLE_BITS'(item.sample);
		if (32'(count_q) > tti_pkg::TABLE_DEPTH) begin
			last_c = tti_pkg::IDX_W'(tti_pkg::TABLE_DEPTH - 1);
		end else if (count_q < tti_pkg::COUNT_W'(2)) begin
			last_c = tti_pkg::IDX_W'(1);
		end else begin
			last_c = tti_pkg::IDX_W'(count_q - 1'b1);
		end
		short_c = (tti_pkg::THRESH_W'(smp_c) <= short_q);
		open_c  = (tti_pkg::THRESH_W'(smp_c) >= open_q);

		// table ends: port a holds entry zero, port b the last entry
		above_c = (s_q > rd_a);
		below_c = (s_q < rd_b);

		// one binary search step; port a holds table[mid], port b table[mid+1] (table[mid] at the last entry)
		mid_p1  = {1'b0, mid_q} + 1'b1;
		mid_m1  = {1'b0, mid_q} - 1'b1;
		found_c = 1'b0;
		lo_nxt  = lo_q;
		hi_nxt  = hi_q;
		if (s_q == rd_a) begin
			found_c = 1'b1;
		end else if ((mid_q < last_q) && (s_q < rd_a) && (s_q > rd_b)) begin
			found_c = 1'b1;
		end else if (s_q < rd_a) begin
			lo_nxt = mid_p1;
			if (mid_p1 > hi_q) begin
				found_c = 1'b1;
			end
		end else begin
			hi_nxt = mid_m1;
			if ((mid_q == '0) || (lo_q > mid_m1)) begin
				found_c = 1'b1;
			end
		end
		sum_c   = {1'b0, lo_nxt} + {1'b0, hi_nxt};
		mid_nxt = tti_pkg::IDX_W'(sum_c >> 1);

		// segment slope terms, divided as magnitudes and signed afterwards
		num_c       = $signed({1'b0, rd_a}) - $signed({1'b0, s_q});
		den_c       = $signed({1'b0, rd_a}) - $signed({1'b0, rd_b});
		abs_num     = tti_pkg::SAMPLE_BITS'(num_c[tti_pkg::DIFF_W-1] ? -num_c : num_c);
		abs_den     = tti_pkg::SAMPLE_BITS'(den_c[tti_pkg::DIFF_W-1] ? -den_c : den_c);
		frac_need_c = (mid_q < last_q) && (den_c != '0);

		// (base + mid) << F plus signed fraction, then saturate
		bm_c   = tti_pkg::BM_W'(base_q) + $signed({{(tti_pkg::BM_W-tti_pkg::IDX_W){1'b0}},
		                                          mid_q});
		q_c    = $signed({1'b0, div_sts.quotient});
		frac_c = !frac_en_q ? '0 : (neg_q ? tti_pkg::ACC_W'(-q_c) : tti_pkg::ACC_W'(q_c));
		acc_c  = (tti_pkg::ACC_W'(bm_c) <<< tti_pkg::FRACTION_BITS) + frac_c;
		if (int'(acc_c) > tti_pkg::TEMP_MAX) begin
			sat_c = tti_pkg::TEMP_W'(tti_pkg::TEMP_MAX);
		end else if (int'(acc_c) < tti_pkg::TEMP_MIN) begin
			sat_c = tti_pkg::TEMP_W'(tti_pkg::TEMP_MIN);
		end else begin
			sat_c = acc_c[tti_pkg::TEMP_W-1:0];
		end
	end

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			tti_pkg::S_IDLE: begin
				if (acc_conv) begin
					state_nxt = (short_c || open_c) ? tti_pkg::S_DONE : tti_pkg::S_ENDS_RD;
				end
			end
			tti_pkg::S_ENDS_RD:  state_nxt = tti_pkg::S_ENDS_CHK;
			tti_pkg::S_ENDS_CHK: begin
				state_nxt = (above_c || below_c) ? tti_pkg::S_DONE : tti_pkg::S_SRCH_RD;
			end
			tti_pkg::S_SRCH_RD:  state_nxt = tti_pkg::S_SRCH_CHK;
			tti_pkg::S_SRCH_CHK: begin
				if (!found_c) begin
					state_nxt = tti_pkg::S_SRCH_RD;
				end else if (frac_need_c) begin
					state_nxt = tti_pkg::S_DIV;
				end else begin
					state_nxt = tti_pkg::S_FINISH;
				end
			end
			tti_pkg::S_DIV: begin
				if (div_sts.done) begin
					state_nxt = tti_pkg::S_FINISH;
				end
			end
			tti_pkg::S_FINISH:   state_nxt = tti_pkg::S_DONE;
			tti_pkg::S_DONE: begin
				if (out_free) begin
					state_nxt = tti_pkg::S_IDLE;
				end
			end
			default: state_nxt = tti_pkg::S_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// Sequencer outputs: handshake, table read addresses, divider start
	// ------------------------------------------------------------------
	always_comb begin
		item.ready       = (state_q == tti_pkg::S_IDLE);
		ram_we           = acc_item && (tti_pkg::op_t'(item.op) == tti_pkg::OP_LOAD) &&
		                   (32'(item.entry_index) < tti_pkg::TABLE_DEPTH);
		ram_waddr        = tti_pkg::IDX_W'(item.entry_index);
		raddr_a          = '0;
		raddr_b          = '0;
		div_ctl.start    = 1'b0;
		div_ctl.dividend = tti_pkg::NUM_W'(abs_num) << tti_pkg::FRACTION_BITS;
		div_ctl.divisor  = abs_den;
		unique case (state_q)
			tti_pkg::S_ENDS_RD: begin
				raddr_a = '0;
				raddr_b = last_q;
			end
			tti_pkg::S_SRCH_RD: begin
				// never read past the last entry in use
				raddr_a = mid_q;
				raddr_b = (mid_q < last_q) ? tti_pkg::IDX_W'(mid_p1) : mid_q;
			end
			tti_pkg::S_SRCH_CHK: begin
				div_ctl.start = found_c && frac_need_c;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tti_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if ((state_q == tti_pkg::S_DONE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			tti_pkg::S_IDLE: begin
				if (acc_conv) begin
					s_q    <= smp_c;
					last_q <= last_c;
					res_q  <= '0;
					// short wins over open
					status_q <= short_c ? tti_pkg::ST_SHORT :
					            (open_c ? tti_pkg::ST_OPEN : tti_pkg::ST_OK);
				end
			end
			tti_pkg::S_ENDS_CHK: begin
				status_q <= above_c ? tti_pkg::ST_ABOVE :
				            (below_c ? tti_pkg::ST_BELOW : tti_pkg::ST_OK);
				lo_q     <= '0;
				hi_q     <= {1'b0, last_q};
				mid_q    <= last_q >> 1;
			end
			tti_pkg::S_SRCH_CHK: begin
				if (found_c) begin
					frac_en_q <= frac_need_c;
					neg_q     <= num_c[tti_pkg::DIFF_W-1] ^ den_c[tti_pkg::DIFF_W-1];
				end else begin
					lo_q  <= lo_nxt;
					hi_q  <= hi_nxt;
					mid_q <= mid_nxt;
				end
			end
			tti_pkg::S_FINISH: begin
				res_q <= sat_c;
			end
			default: ;
		endcase
		if ((state_q == tti_pkg::S_DONE) && out_free) begin
			out_status_q <= status_q;
			out_temp_q   <= res_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.status         = out_status_q;
	assign result.temperature_q8 = out_temp_q;

endmodule

### src/tti_checker.sv
`include "thermistor_table_interpolator_macros.svh"

module tti_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_ready,
	input logic [tti_pkg::OP_W-1:0]          in_op,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic [tti_pkg::STATUS_W-1:0]      out_status,
	input logic signed [tti_pkg::TEMP_W-1:0] out_temp
);

	`TTI_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_temp), "result beat dropped or changed while stalled")
	`TTI_ASSERT_SAME(a_fault_zero, clk, arst_n, out_valid && (out_status != tti_pkg::ST_OK), out_temp == '0, "fault result carries a nonzero temperature")
	`TTI_ASSERT_NEXT(a_conv_busy, clk, arst_n, in_valid && in_ready && (in_op == tti_pkg::OP_CONVERT), !in_ready, "new beat taken while a convert is in flight")
	`TTI_ASSERT_NEXT(a_load_silent, clk, arst_n, in_valid && in_ready && (in_op == tti_pkg::OP_LOAD), !$rose(out_valid), "table load produced a result")

endmodule

bind thermistor_table_interpolator tti_checker u_tti_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (item.valid),
	.in_ready   (item.ready),
	.in_op      (item.op),
	.out_valid  (result.valid),
	.out_ready  (result.ready),
	.out_status (result.status),
	.out_temp   (result.temperature_q8)
);

### bench/tb.sv
`timescale 1ns / 100ps

module tb;
	import tti_pkg::*;

	localparam int ITEM_TARGET    = 1700;  // beats on the item channel, loads and converts
	localparam int SETTLE_CYCLES  = 64;    // sized to outlast the longest convert
	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on any channel
	localparam int HOLD_AT        = 600;   // item count that triggers the long result stall
	localparam int HOLD_CYCLES    = 400;
	localparam longint Q_ONE      = 64'sd1 <<< FRACTION_BITS;

	typedef struct {
		status_t                  status;
		logic signed [TEMP_W-1:0] temp_q8;
	} reading_t;

	// one row of the directed walk: either a register write or an item beat
	typedef struct {
		bit                         is_cfg;
		reg_index_t                 reg_sel;
		logic [CFG_DATA_W-1:0]      wdata;
		op_t                        op;
		logic [ENTRY_INDEX_W-1:0]   idx;
		logic [ENTRY_VALUE_W-1:0]   code;
		logic [SAMPLE_W-1:0]        smp;
		bit                         typed;  // want is typed in, not predicted
		reading_t                   want;
	} bench_row_t;

	logic clk;
	logic arst_n;

	tti_item_if   item_ch ();
	tti_result_if result_ch ();
	tti_cfg_if    cfg_ch ();

	thermistor_table_interpolator uut (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (result_ch),
		.cfg    (cfg_ch)
	);

	// ---------------------------------------------------------------------
	// Shadow copy of the block: table contents, which entries were loaded,
	// and the four registers.
	// ---------------------------------------------------------------------
	logic [SAMPLE_BITS-1:0] code_table_copy [TABLE_DEPTH];
	bit                     entry_loaded    [TABLE_DEPTH];
	logic [THRESH_W-1:0]    short_lim;
	logic [THRESH_W-1:0]    open_lim;
	logic [COUNT_W-1:0]     count_reg;
	int                     base_deg;

	// expected readings, oldest first
	reading_t pending_readings [$];
	reading_t no_reading;

	int items_sent;
	int loads_sent;
	int converts_sent;
	int regs_written;
	int results_checked;
	int fail_count;
	int status_seen [5];

	function automatic int code_at(input int i);
		return int'(code_table_copy[i]);
	endfunction

	// entry_count is clamped to 2..TABLE_DEPTH inside the block
	function automatic int last_entry();
		int n;
		n = int'(count_reg);
		if (n < 2) n = 2;
		if (n > TABLE_DEPTH) n = TABLE_DEPTH;
		return n - 1;
	endfunction

	// no idling on either side over this window of items
	function automatic bit steady_stretch();
		return items_sent >= 900 && items_sent < 1150;
	endfunction

	function automatic reading_t predict_reading(input logic [SAMPLE_W-1:0] smp);
		int       s, last, lo, hi, mid;
		longint   acc, num, den;
		reading_t r;
		s = int'(smp);
		last = last_entry();
		r.status = ST_OK;
		r.temp_q8 = '0;
		// fault screen, in priority order
		if (smp <= short_lim) r.status = ST_SHORT;
		else if (smp >= open_lim) r.status = ST_OPEN;
		else if (s > code_at(0)) r.status = ST_ABOVE;
		else if (s < code_at(last)) r.status = ST_BELOW;
		else begin
			// binary search for the segment; table falls with index
			lo = 0;
			hi = last;
			mid = 0;
			while (lo <= hi) begin
				mid = (lo + hi) / 2;
				if (s == code_at(mid)) break;
				if (mid < last && s < code_at(mid) && s > code_at(mid + 1)) break;
				if (s < code_at(mid)) begin
					lo = mid + 1;
				end else begin
					if (mid == 0) break;
					hi = mid - 1;
				end
			end
			acc = longint'(base_deg + mid) * Q_ONE;
			// last entry: whole degree, nothing past the end is read
			if (mid < last) begin
				den = longint'(code_at(mid) - code_at(mid + 1));
				num = longint'(code_at(mid) - s);
				// flat segment gives no fraction
				if (den != 0) acc += (num * Q_ONE) / den;
			end
			if (acc > TEMP_MAX) acc = TEMP_MAX;
			if (acc < TEMP_MIN) acc = TEMP_MIN;
			r.temp_q8 = acc[TEMP_W-1:0];
		end
		return r;
	endfunction

	function automatic bench_row_t conv_row(input logic [SAMPLE_W-1:0] smp, input bit typed,
			input status_t st, input int temp);
		bench_row_t row;
		row = '{1'b0, REG_SHORT, '0, OP_CONVERT, '0, '0, smp, typed, '{st, temp[TEMP_W-1:0]}};
		return row;
	endfunction

	function automatic bench_row_t load_row(input logic [ENTRY_INDEX_W-1:0] idx,
			input logic [ENTRY_VALUE_W-1:0] code);
		bench_row_t row;
		row = '{1'b0, REG_SHORT, '0, OP_LOAD, idx, code, '0, 1'b0, '{ST_OK, '0}};
		return row;
	endfunction

	function automatic bench_row_t cfg_row(input reg_index_t sel, input logic [CFG_DATA_W-1:0] d);
		bench_row_t row;
		row = '{1'b1, sel, d, OP_LOAD, '0, '0, '0, 1'b0, '{ST_OK, '0}};
		return row;
	endfunction

	// One item beat. Random idle cycles before it; valid stays high after the
	// beat so back-to-back items never drop it within a step.
	task automatic send_item(input op_t op, input logic [ENTRY_INDEX_W-1:0] idx,
			input logic [ENTRY_VALUE_W-1:0] code, input logic [SAMPLE_W-1:0] smp,
			input bit typed, input reading_t want);
		while (!steady_stretch() && $urandom_range(99, 0) < 8) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid       <= 1'b1;
		item_ch.op          <= op;
		item_ch.entry_index <= idx;
		item_ch.entry_value <= code;
		item_ch.sample      <= smp;
		do @(posedge clk); while (item_ch.ready !== 1'b1);
		items_sent++;
		if (op == OP_LOAD) begin
			code_table_copy[idx] = code;
			entry_loaded[idx] = 1'b1;
			loads_sent++;
		end else begin
			pending_readings.push_back(typed ? want : predict_reading(smp));
			converts_sent++;
		end
	endtask

	// Block goes idle: stop offering, wait out every reading, then let any
	// trailing work finish before the registers move.
	task automatic settle();
		item_ch.valid <= 1'b0;
		while (pending_readings.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// release drops valid after the beat; only the last write of a batch does
	task automatic write_reg(input reg_index_t sel, input logic [CFG_DATA_W-1:0] d,
			input bit release_ch);
		cfg_ch.valid     <= 1'b1;
		cfg_ch.reg_index <= sel;
		cfg_ch.wdata     <= d;
		do @(posedge clk); while (cfg_ch.ready !== 1'b1);
		if (release_ch) cfg_ch.valid <= 1'b0;
		case (sel)
			REG_SHORT: short_lim = d[THRESH_W-1:0];
			REG_OPEN:  open_lim = d[THRESH_W-1:0];
			REG_COUNT: count_reg = d[COUNT_W-1:0];
			REG_BASE:  base_deg = $signed(d[BASE_W-1:0]);
			default: ;
		endcase
		regs_written++;
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// ---------------------------------------------------------------------
	// Result side: random back-pressure, plus one long hold-off so the
	// block backs up and stalls its item input.
	// ---------------------------------------------------------------------
	initial begin : result_sink
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 1'b0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (!hold_done && items_sent >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= steady_stretch() || $urandom_range(99, 0) >= 8;
			end
		end
	end

	// every result beat against the oldest expected reading
	always @(posedge clk) begin : check_results
		reading_t want;
		if (result_ch.valid === 1'b1 && result_ch.ready === 1'b1) begin
			if (pending_readings.size() == 0) begin
				$error("unexpected result beat: status %0d temperature_q8 %0d",
					result_ch.status, $signed(result_ch.temperature_q8));
				fail_count++;
			end else begin
				want = pending_readings.pop_front();
				if (result_ch.status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, result_ch.status);
					fail_count++;
				end
				if (result_ch.temperature_q8 !== want.temp_q8) begin
					$error("temperature_q8: expected %0d, actual %0d",
						$signed(want.temp_q8), $signed(result_ch.temperature_q8));
					fail_count++;
				end
				results_checked++;
				if (int'(want.status) < 5) status_seen[want.status]++;
			end
		end
	end

	// counts cycles with no beat anywhere; a hang ends the run
	initial begin : watchdog
		int dead_cycles;
		dead_cycles = 0;
		while (dead_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((item_ch.valid === 1'b1 && item_ch.ready === 1'b1) ||
					(result_ch.valid === 1'b1 && result_ch.ready === 1'b1) ||
					(cfg_ch.valid === 1'b1 && cfg_ch.ready === 1'b1))
				dead_cycles = 0;
			else
				dead_cycles++;
		end
		$display("watchdog: no beat for %0d cycles, %0d readings outstanding",
			WATCHDOG_LIMIT, pending_readings.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		bench_row_t                 rows [$];
		int                         n_last, code, step_max, n_conv, pick, phase_no, t, lo_c, hi_c;
		logic [THRESH_W-1:0]        new_short, new_open;
		logic [COUNT_W-1:0]         new_count;
		logic [BASE_W-1:0]          new_base;

		arst_n              <= 1'b0;
		item_ch.valid       <= 1'b0;
		item_ch.op          <= OP_LOAD;
		item_ch.entry_index <= '0;
		item_ch.entry_value <= '0;
		item_ch.sample      <= '0;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.reg_index    <= REG_SHORT;
		cfg_ch.wdata        <= '0;
		no_reading = '{ST_OK, '0};
		short_lim = SHORT_RESET;
		open_lim  = OPEN_RESET;
		count_reg = COUNT_RESET;
		base_deg  = BASE_RESET;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// --- directed walk -------------------------------------------------
		// reset thresholds: short and open fire before any table read
		rows.push_back(conv_row(12'd0,    1'b1, ST_SHORT, 0));
		rows.push_back(conv_row(12'd20,   1'b1, ST_SHORT, 0));
		rows.push_back(conv_row(12'd4090, 1'b1, ST_OPEN,  0));
		rows.push_back(conv_row(12'd4095, 1'b1, ST_OPEN,  0));
		// four-entry table with a flat middle segment
		rows.push_back(cfg_row(REG_COUNT, 12'd4));
		rows.push_back(load_row(8'd0, 12'd3000));
		rows.push_back(load_row(8'd1, 12'd2000));
		rows.push_back(load_row(8'd2, 12'd2000));
		rows.push_back(load_row(8'd3, 12'd1000));
		rows.push_back(load_row(8'd255, 12'd4095));
		rows.push_back(load_row(8'd200, 12'd0));
		rows.push_back(conv_row(12'd3001, 1'b1, ST_ABOVE, 0));
		rows.push_back(conv_row(12'd999,  1'b1, ST_BELOW, 0));
		rows.push_back(conv_row(12'd3000, 1'b1, ST_OK, -40 * 256));  // exact hit on entry 0
		rows.push_back(conv_row(12'd1000, 1'b1, ST_OK, -37 * 256));  // exact hit on last entry
		rows.push_back(conv_row(12'd2000, 1'b0, ST_OK, 0));          // flat segment
		rows.push_back(conv_row(12'd2500, 1'b0, ST_OK, 0));
		rows.push_back(conv_row(12'd1001, 1'b0, ST_OK, 0));
		// threshold extremes, top base, count below the minimum
		rows.push_back(cfg_row(REG_SHORT, 12'd0));
		rows.push_back(cfg_row(REG_OPEN,  12'd4095));
		rows.push_back(cfg_row(REG_BASE,  12'd127));
		rows.push_back(cfg_row(REG_COUNT, 12'd1));
		rows.push_back(conv_row(12'd0,    1'b1, ST_SHORT, 0));
		rows.push_back(conv_row(12'd4095, 1'b1, ST_OPEN,  0));
		rows.push_back(conv_row(12'd4094, 1'b1, ST_ABOVE, 0));
		rows.push_back(conv_row(12'd2000, 1'b1, ST_OK, TEMP_MAX));   // 128 degrees saturates
		rows.push_back(conv_row(12'd2500, 1'b0, ST_OK, 0));
		// short wins over open when both match
		rows.push_back(cfg_row(REG_SHORT, 12'd4095));
		rows.push_back(conv_row(12'd4095, 1'b1, ST_SHORT, 0));

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				if (i == 0 || !rows[i-1].is_cfg) settle();
				write_reg(rows[i].reg_sel, rows[i].wdata,
					i == rows.size() - 1 || !rows[i+1].is_cfg);
			end else begin
				send_item(rows[i].op, rows[i].idx, rows[i].code, rows[i].smp,
					rows[i].typed, rows[i].want);
			end
		end

		// --- random phases -------------------------------------------------
		// Each phase: drain, new register set, (re)load the active part of the
		// table, then a run of conversions with stray loads mixed in.
		phase_no = 0;
		while (items_sent < ITEM_TARGET) begin
			if (phase_no == 0) begin
				// full-depth table, count above range, lowest base
				new_short = '0;
				new_open  = '1;
				new_count = 9'd511;
				new_base  = 8'h80;
			end else begin
				pick = $urandom_range(99, 0);
				new_short = (pick < 4) ? 12'd0 : (pick < 8) ? 12'd4095 :
					12'($urandom_range(300, 0));
				pick = $urandom_range(99, 0);
				new_open = (pick < 4) ? 12'd0 : (pick < 8) ? 12'd4095 :
					12'($urandom_range(4095, 3800));
				pick = $urandom_range(99, 0);
				if (pick < 6) begin
					case ($urandom_range(5, 0))
						0: new_count = 9'd0;
						1: new_count = 9'd1;
						2: new_count = 9'd2;
						3: new_count = 9'd256;
						4: new_count = 9'd257;
						default: new_count = 9'd511;
					endcase
				end else if (pick < 10) begin
					new_count = 9'($urandom_range(256, 100));
				end else begin
					new_count = 9'($urandom_range(40, 2));
				end
				pick = $urandom_range(99, 0);
				new_base = (pick < 5) ? 8'h80 : (pick < 10) ? 8'h7f : (pick < 15) ? 8'h00 :
					8'($urandom);
			end
			settle();
			// upper data bits beyond each register's width are don't-care
			write_reg(REG_SHORT, new_short, 1'b0);
			write_reg(REG_OPEN, new_open, 1'b0);
			write_reg(REG_COUNT, {3'($urandom), new_count}, 1'b0);
			write_reg(REG_BASE, {4'($urandom), new_base}, 1'b1);
			n_last = last_entry();

			pick = (phase_no == 0) ? 0 : $urandom_range(99, 0);
			if (pick < 70) begin
				// well-formed falling table, some flat steps
				code = $urandom_range(4095, 1500);
				step_max = (2 * code) / (n_last + 1) + 1;
				for (int i = 0; i <= n_last; i++) begin
					send_item(OP_LOAD, 8'(i), 12'(code), 12'($urandom), 1'b0, no_reading);
					if ($urandom_range(9, 0) != 0) code -= $urandom_range(step_max, 1);
					if (code < 0) code = 0;
				end
			end else if (pick < 85) begin
				// scrambled table: search still has to land somewhere defined
				for (int i = 0; i <= n_last; i++)
					send_item(OP_LOAD, 8'(i), 12'($urandom), 12'($urandom), 1'b0, no_reading);
			end else begin
				// keep what is there, fill only the holes in the active range
				for (int i = 0; i <= n_last; i++)
					if (!entry_loaded[i])
						send_item(OP_LOAD, 8'(i), 12'($urandom), 12'($urandom), 1'b0,
							no_reading);
			end

			lo_c = code_at(n_last);
			hi_c = code_at(0);
			if (lo_c > hi_c) begin
				t = lo_c;
				lo_c = hi_c;
				hi_c = t;
			end
			n_conv = $urandom_range(50, 20);
			repeat (n_conv) begin
				pick = $urandom_range(99, 0);
				if (pick < 12) begin
					// stray load anywhere, may break the ordering
					send_item(OP_LOAD, 8'($urandom), 12'($urandom), 12'($urandom), 1'b0,
						no_reading);
				end else begin
					pick = $urandom_range(99, 0);
					if (pick < 50) begin
						t = $urandom_range(hi_c, lo_c);
					end else if (pick < 65) begin
						t = code_at($urandom_range(n_last, 0));
					end else if (pick < 75) begin
						t = code_at($urandom_range(n_last, 0)) + ($urandom_range(1, 0) ? 1 : -1);
					end else if (pick < 85) begin
						t = ($urandom_range(1, 0) ? int'(short_lim) : int'(open_lim)) +
							$urandom_range(2, 0) - 1;
					end else begin
						t = $urandom_range(4095, 0);
					end
					if (t < 0) t = 0;
					if (t > 4095) t = 4095;
					send_item(OP_CONVERT, 8'($urandom), 12'($urandom), 12'(t), 1'b0,
						no_reading);
				end
			end
			phase_no++;
		end

		settle();
		$display("Covered %0d item beats (%0d conversions, %0d table loads), %0d register writes, %0d table setups.",
			items_sent, converts_sent, loads_sent, regs_written, phase_no);
		$display("Checked %0d readings: %0d ok, %0d short, %0d open, %0d above top, %0d below bottom.",
			results_checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3],
			status_seen[4]);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sim.f
+incdir+src
src/tti_pkg.sv
src/tti_item_if.sv
src/tti_result_if.sv
src/tti_cfg_if.sv
src/tti_ram.sv
src/tti_div.sv
src/thermistor_table_interpolator.sv
src/tti_checker.sv
bench/tb.sv
